// ===== sv/integer_to_ascii_formatter_macros.svh =====
// Assertion macros shared by the formatter RTL files.
// Each macro expects clk and rst_n to be visible in the module that uses it.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define I2A_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("integer_to_ascii_formatter: same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define I2A_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("integer_to_ascii_formatter: next-cycle check failed");

`endif

// ===== sv/i2a_pkg.sv =====
// Shared types and constants for the integer-to-ASCII formatter.
// Used by i2a_bcd_conv and integer_to_ascii_formatter; depends on nothing.
package i2a_pkg;

    localparam int VALUE_BITS_DEF = 64;
    localparam int CHAR_W         = 8;
    localparam int COUNT_W        = 5;

    typedef enum logic [1:0] {
        CMD_DEC    = 2'd0,
        CMD_HEX_LO = 2'd1,
        CMD_HEX_UP = 2'd2,
        CMD_PTR    = 2'd3
    } cmd_t;

    typedef logic [CHAR_W-1:0] char_t;

    localparam char_t ASC_ZERO    = 8'h30;
    localparam char_t ASC_LOWER_A = 8'h61;
    localparam char_t ASC_UPPER_A = 8'h41;
    localparam char_t ASC_MINUS   = 8'h2D;
    localparam char_t ASC_X       = 8'h78;
    localparam char_t ASC_LPAREN  = 8'h28;
    localparam char_t ASC_RPAREN  = 8'h29;
    localparam char_t ASC_N       = 8'h6E;
    localparam char_t ASC_I       = 8'h69;
    localparam char_t ASC_L       = 8'h6C;

    // Status of the binary-to-BCD converter as seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } conv_stat_t;

endpackage

// ===== sv/integer_to_ascii_formatter.sv =====
// Sequence: hex and nonzero pointer requests go from S_IDLE to S_SCAN, then to S_PREFIX
// when a sign or 0x prefix is due, then to S_DIGITS; a zero pointer goes straight to
// S_PREFIX; decimal requests first wait in S_CONV for the BCD converter that shifts four
// bits per cycle. One char per cycle while out_ready holds. Requests: one at a time; the
// next is taken once the last character is loaded into the output register.
// Reset: rst_n is asynchronous, active low, and clears the sequencer and output valid.
`include "integer_to_ascii_formatter_macros.svh"

module integer_to_ascii_formatter #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   command,
    input  logic [63:0]                  value,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [i2a_pkg::CHAR_W-1:0]   char_out,
    output logic                         last,
    output logic [i2a_pkg::COUNT_W-1:0]  char_count
);

    localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int BUF_W  = 4 * DIGITS;
    localparam int IDX_W  = $clog2(DIGITS);
    localparam int NDIG_W = $clog2(DIGITS + 1);
    localparam int CW     = i2a_pkg::COUNT_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CONV   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_PREFIX = 5'b01000,
        S_DIGITS = 5'b10000
    } state_t;

    function automatic i2a_pkg::char_t digit_char(input logic [3:0] d, input logic upper);
        i2a_pkg::char_t base;
        base = upper ? i2a_pkg::ASC_UPPER_A : i2a_pkg::ASC_LOWER_A;
        if (d < 4'd10)
        begin
            return i2a_pkg::ASC_ZERO + {4'd0, d};
        end
        return base + {4'd0, d} - 8'd10;
    endfunction

    function automatic i2a_pkg::char_t prefix_char(input i2a_pkg::cmd_t cmd, input logic nil,
                                                   input logic [2:0] idx);
        i2a_pkg::char_t c;
        c = i2a_pkg::ASC_MINUS;
        if (nil)
        begin
            unique case (idx)
                3'd0:    c = i2a_pkg::ASC_LPAREN;
                3'd1:    c = i2a_pkg::ASC_N;
                3'd2:    c = i2a_pkg::ASC_I;
                3'd3:    c = i2a_pkg::ASC_L;
                default: c = i2a_pkg::ASC_RPAREN;
            endcase
        end
        else if (cmd == i2a_pkg::CMD_PTR)
        begin
            c = (idx == 3'd0) ? i2a_pkg::ASC_ZERO : i2a_pkg::ASC_X;
        end
        return c;
    endfunction

    state_t                  state_reg, state_next;
    i2a_pkg::cmd_t           cmd_reg, cmd_next;
    logic                    nil_reg, nil_next;
    logic [2:0]              plen_reg, plen_next;
    logic [2:0]              pre_idx_reg, pre_idx_next;
    logic [BUF_W-1:0]        buf_reg, buf_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [CW-1:0]           total_reg, total_next;
    logic                    out_valid_reg, out_valid_next;
    i2a_pkg::char_t          char_reg, char_next;
    logic                    last_reg, last_next;
    logic [CW-1:0]           count_reg, count_next;

    logic                    accept;
    logic                    emit_ok;
    i2a_pkg::cmd_t           cmd_in;
    logic [VALUE_BITS-1:0]   v;
    logic                    neg;
    logic [VALUE_BITS-1:0]   mag;
    logic                    conv_start;
    i2a_pkg::conv_stat_t     conv_stat;
    logic [BUF_W-1:0]        conv_bcd;
    logic [NDIG_W-1:0]       ndig;
    logic [3:0]              cur_digit;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign emit_ok  = !out_valid_reg || out_ready;
    assign cmd_in   = i2a_pkg::cmd_t'(command);
    assign v        = value[VALUE_BITS-1:0];
    assign neg      = (cmd_in == i2a_pkg::CMD_DEC) && v[VALUE_BITS-1];
    // The most negative value negates to itself, which read as unsigned is its magnitude.
    assign mag      = neg ? (~v + VALUE_BITS'(1)) : v;
    assign conv_start = accept && (cmd_in == i2a_pkg::CMD_DEC);
    assign cur_digit  = buf_reg[{idx_reg, 2'b00} +: 4];

    i2a_bcd_conv #(
        .VALUE_BITS (VALUE_BITS)
    ) u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .mag   (mag),
        .stat  (conv_stat),
        .bcd   (conv_bcd)
    );

    // Position of the most significant nonzero digit; zero still prints one digit.
    always_comb
    begin
        ndig = NDIG_W'(1);
        for (int i = 0; i < DIGITS; i++)
        begin
            if (buf_reg[4*i +: 4] != 4'd0)
            begin
                ndig = NDIG_W'(i + 1);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        nil_next       = nil_reg;
        plen_next      = plen_reg;
        pre_idx_next   = pre_idx_reg;
        buf_next       = buf_reg;
        idx_next       = idx_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        char_next      = char_reg;
        last_next      = last_reg;
        count_next     = count_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next     = cmd_in;
                    nil_next     = 1'b0;
                    pre_idx_next = 3'd0;
                    buf_next     = BUF_W'(v);
                    unique case (cmd_in)
                        i2a_pkg::CMD_DEC:
                        begin
                            plen_next  = neg ? 3'd1 : 3'd0;
                            state_next = S_CONV;
                        end
                        i2a_pkg::CMD_HEX_LO, i2a_pkg::CMD_HEX_UP:
                        begin
                            plen_next  = 3'd0;
                            state_next = S_SCAN;
                        end
                        i2a_pkg::CMD_PTR:
                        begin
                            if (v == '0)
                            begin
                                nil_next   = 1'b1;
                                plen_next  = 3'd5;
                                total_next = CW'(5);
                                state_next = S_PREFIX;
                            end
                            else
                            begin
                                plen_next  = 3'd2;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CONV:
            begin
                if (conv_stat.done)
                begin
                    buf_next   = conv_bcd;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                idx_next   = IDX_W'(ndig - NDIG_W'(1));
                total_next = CW'(plen_reg) + CW'(ndig);
                state_next = (plen_reg != 3'd0) ? S_PREFIX : S_DIGITS;
            end
            S_PREFIX:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    char_next      = prefix_char(cmd_reg, nil_reg, pre_idx_reg);
                    last_next      = 1'b0;
                    count_next     = '0;
                    if (pre_idx_reg == plen_reg - 3'd1)
                    begin
                        if (nil_reg)
                        begin
                            last_next  = 1'b1;
                            count_next = total_reg;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_DIGITS;
                        end
                    end
                    else
                    begin
                        pre_idx_next = pre_idx_reg + 3'd1;
                    end
                end
            end
            S_DIGITS:
            begin
                if (emit_ok)
                begin
                    out_valid_next = 1'b1;
                    char_next      = digit_char(cur_digit, cmd_reg == i2a_pkg::CMD_HEX_UP);
                    last_next      = 1'b0;
                    count_next     = '0;
                    if (idx_reg == '0)
                    begin
                        last_next  = 1'b1;
                        count_next = total_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg - IDX_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        nil_reg     <= nil_next;
        plen_reg    <= plen_next;
        pre_idx_reg <= pre_idx_next;
        buf_reg     <= buf_next;
        idx_reg     <= idx_next;
        total_reg   <= total_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
        count_reg   <= count_next;
    end

    assign out_valid  = out_valid_reg;
    assign char_out   = char_reg;
    assign last       = last_reg;
    assign char_count = count_reg;

    `I2A_ASSERT_SAME(a_last_has_count, out_valid_reg && last_reg, count_reg != '0)
    `I2A_ASSERT_SAME(a_mid_no_count, out_valid_reg && !last_reg, count_reg == '0)
    `I2A_ASSERT_NEXT(a_busy_after_accept, accept, !in_ready)
    `I2A_ASSERT_SAME(a_done_in_conv, conv_stat.done, state_reg == S_CONV)

endmodule

// ===== sv/i2a_bcd_conv.sv =====
// Iterative binary-to-BCD converter (shift and add-3), four bits per cycle.
// Depends on i2a_pkg and integer_to_ascii_formatter_macros.svh.
`include "integer_to_ascii_formatter_macros.svh"

module i2a_bcd_conv #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        start,
    input  logic [VALUE_BITS-1:0]                       mag,
    output i2a_pkg::conv_stat_t                         stat,
    output logic [4*((VALUE_BITS*1233)/4096+1)-1:0]     bcd
);

    localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
    localparam int BUF_W  = 4 * DIGITS;
    localparam int STEPS  = (VALUE_BITS + 3) / 4;
    localparam int SRC_W  = 4 * STEPS;
    localparam int CNT_W  = $clog2(STEPS + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [SRC_W-1:0] src_reg, src_next;
    logic [BUF_W-1:0] bcd_reg, bcd_next;

    always_comb
    begin
        logic [BUF_W-1:0] b;
        logic [SRC_W-1:0] s;
        b = bcd_reg;
        s = src_reg;
        // Four shift-and-correct steps per cycle; digits within one step are independent.
        for (int k = 0; k < 4; k++)
        begin
            for (int j = 0; j < DIGITS; j++)
            begin
                if (b[4*j +: 4] >= 4'd5)
                begin
                    b[4*j +: 4] = b[4*j +: 4] + 4'd3;
                end
            end
            b = {b[BUF_W-2:0], s[SRC_W-1]};
            s = {s[SRC_W-2:0], 1'b0};
        end

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        src_next  = src_reg;
        bcd_next  = bcd_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(STEPS);
            src_next  = SRC_W'(mag);
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = b;
            src_next = s;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        src_reg <= src_next;
        bcd_reg <= bcd_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign bcd       = bcd_reg;

    `I2A_ASSERT_NEXT(a_start_sets_busy, start, busy_reg)
    `I2A_ASSERT_SAME(a_done_not_busy, done_reg, !busy_reg)
    `I2A_ASSERT_SAME(a_no_restart_busy, start, !busy_reg)

endmodule
